@@ src/rsc_pkg.sv @@
`default_nettype none

package rsc_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW      = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned DivCntW    = $clog2(DataW);
  localparam int unsigned StepW      = 4;

  localparam logic [7:0] SymAdd  = 8'd43;
  localparam logic [7:0] SymSub  = 8'd45;
  localparam logic [7:0] SymMul  = 8'd42;
  localparam logic [7:0] SymDiv  = 8'd47;
  localparam logic [7:0] SymZero = 8'd48;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] answer;
    logic                    divide_by_zero;
    logic                    stack_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_WAIT_IN,
    COND_DIGIT,
    COND_NOT_DIV,
    COND_A_ZERO,
    COND_WAIT_DIV,
    COND_FINISH
  } cond_e;

  typedef logic [StepW-1:0] step_t;

  // Control word fields that drive the datapath
  typedef struct packed {
    logic accept;
    logic pop;
    logic load_a;
    logic load_b;
    logic res_alu;
    logic res_div;
    logic res_digit;
    logic push;
    logic set_ans;
    logic set_dz;
    logic div_start;
    logic finish;
  } ctl_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic is_digit;
    logic is_div;
    logic a_zero;
    logic div_busy;
    logic emit_hold;
  } status_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_e cond;
    step_t target;
  } uword_t;

  localparam step_t StepIdle    = 4'd0;
  localparam step_t StepDecode  = 4'd1;
  localparam step_t StepPopA    = 4'd2;
  localparam step_t StepPopB    = 4'd3;
  localparam step_t StepLoadB   = 4'd4;
  localparam step_t StepZeroChk = 4'd5;
  localparam step_t StepDivGo   = 4'd6;
  localparam step_t StepDivWait = 4'd7;
  localparam step_t StepDivPush = 4'd8;
  localparam step_t StepAlu     = 4'd9;
  localparam step_t StepAluPush = 4'd10;
  localparam step_t StepDivZero = 4'd11;
  localparam step_t StepDigit   = 4'd12;
  localparam step_t StepDigPush = 4'd13;
  localparam step_t StepFinish  = 4'd14;

  localparam ctl_t CtlNone = '0;

  function automatic op_e decode_op(logic [7:0] sym);
    op_e op;
    priority if (sym == SymAdd) begin
      op = OP_ADD;
    end else if (sym == SymSub) begin
      op = OP_SUB;
    end else if (sym == SymMul) begin
      op = OP_MUL;
    end else if (sym == SymDiv) begin
      op = OP_DIV;
    end else begin
      op = OP_PUSH;
    end
    return op;
  endfunction

  function automatic uword_t ucode(step_t step);
    uword_t w;
    w = '{ctl: CtlNone, cond: COND_JUMP, target: StepIdle};
    unique case (step)
      StepIdle: begin
        w.ctl.accept = 1'b1;
        w.cond       = COND_WAIT_IN;
      end
      StepDecode: begin
        w.cond   = COND_DIGIT;
        w.target = StepDigit;
      end
      StepPopA: begin
        w.ctl.pop = 1'b1;
        w.cond    = COND_NEXT;
      end
      StepPopB: begin
        w.ctl.load_a = 1'b1;
        w.ctl.pop    = 1'b1;
        w.cond       = COND_NEXT;
      end
      StepLoadB: begin
        w.ctl.load_b = 1'b1;
        w.cond       = COND_NOT_DIV;
        w.target     = StepAlu;
      end
      StepZeroChk: begin
        w.cond   = COND_A_ZERO;
        w.target = StepDivZero;
      end
      StepDivGo: begin
        w.ctl.div_start = 1'b1;
        w.cond          = COND_NEXT;
      end
      StepDivWait: begin
        w.cond = COND_WAIT_DIV;
      end
      StepDivPush: begin
        w.ctl.res_div = 1'b1;
        w.cond        = COND_JUMP;
        w.target      = StepAluPush;
      end
      StepAlu: begin
        w.ctl.res_alu = 1'b1;
        w.cond        = COND_NEXT;
      end
      StepAluPush: begin
        w.ctl.push    = 1'b1;
        w.ctl.set_ans = 1'b1;
        w.cond        = COND_JUMP;
        w.target      = StepFinish;
      end
      StepDivZero: begin
        w.ctl.set_dz = 1'b1;
        w.cond       = COND_JUMP;
        w.target     = StepFinish;
      end
      StepDigit: begin
        w.ctl.res_digit = 1'b1;
        w.cond          = COND_NEXT;
      end
      StepDigPush: begin
        w.ctl.push = 1'b1;
        w.cond     = COND_NEXT;
      end
      StepFinish: begin
        w.ctl.finish = 1'b1;
        w.cond       = COND_FINISH;
        w.target     = StepIdle;
      end
      default: begin
        w.cond   = COND_JUMP;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/rsc_divider.sv @@
`default_nettype none

module rsc_divider
  import rsc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] num_i,
  input  wire logic [DataW-1:0] den_i,
  output logic                  busy_o,
  output logic [DataW-1:0]      quo_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DataW-1:0]   rem_q;
  logic [DataW-1:0]   quo_q;
  logic [DataW-1:0]   den_q;
  logic               neg_q;
  logic [DataW:0]     shifted;
  logic [DataW:0]     diff;
  logic               fits;

  assign shifted = {rem_q, quo_q[DataW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = ~diff[DataW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DataW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[DataW-1] ? (DataW'(0) - num_i) : num_i;
      den_q <= den_i[DataW-1] ? (DataW'(0) - den_i) : den_i;
      rem_q <= '0;
      neg_q <= num_i[DataW-1] ^ den_i[DataW-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[DataW-1:0] : shifted[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

@@ src/rsc_datapath.sv @@
`default_nettype none

module rsc_datapath
  import rsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctl_t      ctl_i,
  input  wire logic      in_valid_i,
  input  wire in_item_t  in_item_i,
  output status_t        status_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic [7:0]       sym_q;
  logic             last_q;
  op_e              op_q;
  logic [SpW-1:0]   sp_q;
  logic [SpW-1:0]   sp_m1;
  logic             empty_q;
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic [DataW-1:0] res_q;
  logic [DataW-1:0] ans_q;
  logic             dz_q;
  logic             ov_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [DataW-1:0] stack_mem [StackDepth];

  logic             in_fire;
  logic             full;
  logic             pop_en;
  logic             push_en;
  logic             out_free;
  logic             emit;
  logic [DataW-1:0] popped;
  logic [DataW-1:0] alu_res;
  logic [DataW-1:0] div_quo;
  logic             div_busy;

  assign in_fire  = ctl_i.accept & in_valid_i;
  assign full     = (sp_q == SpW'(StackDepth));
  assign sp_m1    = sp_q - 1'b1;
  assign pop_en   = ctl_i.pop & (sp_q != '0);
  assign push_en  = ctl_i.push & ~full;
  assign out_free = ~out_valid_q | out_ready_i;
  assign emit     = ctl_i.finish & last_q & out_free;
  assign popped   = empty_q ? '0 : rd_q;

  always_comb begin
    unique case (op_q)
      OP_SUB:  alu_res = b_q - a_q;
      OP_MUL:  alu_res = a_q * b_q;
      default: alu_res = a_q + b_q;
    endcase
  end

  rsc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ctl_i.div_start),
    .num_i  (b_q),
    .den_i  (a_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[sp_q[AddrW-1:0]] <= res_q;
    end
    if (pop_en) begin
      rd_q <= stack_mem[sp_m1[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sym_q <= in_item_i.symbol;
    end
    if (ctl_i.load_a) begin
      a_q <= popped;
    end
    if (ctl_i.load_b) begin
      b_q <= popped;
    end
    priority if (ctl_i.res_digit) begin
      res_q <= DataW'(sym_q) - DataW'(SymZero);
    end else if (ctl_i.res_alu) begin
      res_q <= alu_res;
    end else if (ctl_i.res_div) begin
      res_q <= div_quo;
    end
    if (emit) begin
      out_q.answer         <= $signed(ans_q);
      out_q.divide_by_zero <= dz_q;
      out_q.stack_overflow <= ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      op_q        <= OP_PUSH;
      sp_q        <= '0;
      empty_q     <= 1'b1;
      ans_q       <= '0;
      dz_q        <= 1'b0;
      ov_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        last_q <= in_item_i.end_of_expression;
        op_q   <= decode_op(in_item_i.symbol);
      end
      if (ctl_i.pop) begin
        empty_q <= (sp_q == '0);
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit) begin
        // Hand over the answer and start the next expression clean
        out_valid_q <= 1'b1;
        sp_q        <= '0;
        ans_q       <= '0;
        dz_q        <= 1'b0;
        ov_q        <= 1'b0;
      end else begin
        if (pop_en) begin
          sp_q <= sp_m1;
        end
        if (push_en) begin
          sp_q <= sp_q + 1'b1;
        end
        if (ctl_i.push & full) begin
          ov_q <= 1'b1;
        end
        if (ctl_i.set_ans) begin
          ans_q <= res_q;
        end
        if (ctl_i.res_div) begin
          ans_q <= div_quo;
        end
        if (ctl_i.set_dz) begin
          dz_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.in_fire   = in_fire;
  assign status_o.is_digit  = (op_q == OP_PUSH);
  assign status_o.is_div    = (op_q == OP_DIV);
  assign status_o.a_zero    = (a_q == '0);
  assign status_o.div_busy  = div_busy;
  assign status_o.emit_hold = last_q & ~out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("stack pointer beyond depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (sp_q == '0) && (ans_q == '0) && !dz_q && !ov_q && out_valid_q)
    else $error("state not cleared after answer");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.div_start |-> !div_busy && (a_q != '0))
    else $error("divider started while busy or with zero divisor");

endmodule

`default_nettype wire

@@ src/rsc_sequencer.sv @@
`default_nettype none

module rsc_sequencer
  import rsc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output ctl_t         ctl_o
);

  step_t  step_q;
  step_t  step_d;
  uword_t uw;

  assign uw = ucode(step_q);

  always_comb begin
    unique case (uw.cond)
      COND_NEXT:     step_d = step_q + 1'b1;
      COND_JUMP:     step_d = uw.target;
      COND_WAIT_IN:  step_d = status_i.in_fire ? step_q + 1'b1 : step_q;
      COND_DIGIT:    step_d = status_i.is_digit ? uw.target : step_q + 1'b1;
      COND_NOT_DIV:  step_d = status_i.is_div ? step_q + 1'b1 : uw.target;
      COND_A_ZERO:   step_d = status_i.a_zero ? uw.target : step_q + 1'b1;
      COND_WAIT_DIV: step_d = status_i.div_busy ? step_q : step_q + 1'b1;
      COND_FINISH:   step_d = status_i.emit_hold ? step_q : uw.target;
    endcase
  end

  always_comb begin
    ctl_o = uw.ctl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rpn_stack_calculator.sv @@
`default_nettype none

// Channel   Direction  Payload     Handshake
// in        input      in_item_t   in_valid_i / in_ready_o
// out       output     out_item_t  out_valid_o / out_ready_i
//
// A digit passes the idle, decode, digit, push and finish steps; '+', '-', '*'
// pop both operands, compute, push and finish; '/' sets the flag on a zero
// divisor, else starts the radix-2 divider and holds at its wait step for it.
// The microcode sequencer works on one item at a time; in_ready_o is high
// only at its idle step.
// Reset clears the step counter, stack pointer, answer and flags; the stack
// memory holds no reset value.
// A finished answer waits in the output register; the last item of an
// expression stalls at its final step only while that register is still full.

module rpn_stack_calculator
  import rsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  ctl_t    ctl;
  status_t status;

  rsc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctl_o   (ctl)
  );

  rsc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  assign in_ready_o = ctl.accept;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none

module testbench;
  import rsc_pkg::*;

  localparam int unsigned RandomItems = 1050;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned ReportMax   = 10;
  localparam logic        MidExpr     = 1'b0;
  localparam logic        EndExpr     = 1'b1;

  // Tracks the calculator state and queues the answer each expression ends with.
  class rpn_scoreboard;
    logic [DataW-1:0] stk [StackDepth];
    int unsigned      depth;
    logic [DataW-1:0] ans;
    logic             dz;
    logic             ovf;
    out_item_t        answer_q[$];
    int unsigned      errors;

    function new();
      depth  = 0;
      ans    = '0;
      dz     = 1'b0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    // An empty stack yields zero and stays empty.
    function logic [DataW-1:0] pop_value();
      if (depth == 0) begin
        return '0;
      end
      depth--;
      return stk[depth];
    endfunction

    function void push_value(logic [DataW-1:0] v);
      if (depth >= StackDepth) begin
        ovf = 1'b1;
      end else begin
        stk[depth] = v;
        depth++;
      end
    endfunction

    function void note_input(in_item_t it);
      logic [DataW-1:0] a, b, r, ma, mb, q;
      out_item_t        res;
      if (it.symbol == SymAdd || it.symbol == SymSub ||
          it.symbol == SymMul || it.symbol == SymDiv) begin
        a = pop_value();
        b = pop_value();
        if (it.symbol == SymDiv && a == '0) begin
          dz = 1'b1;
        end else begin
          if (it.symbol == SymAdd) begin
            r = a + b;
          end else if (it.symbol == SymSub) begin
            r = b - a;
          end else if (it.symbol == SymMul) begin
            r = a * b;
          end else begin
            // divide magnitudes, then fix the sign: truncates toward zero
            ma = a[DataW-1] ? (32'd0 - a) : a;
            mb = b[DataW-1] ? (32'd0 - b) : b;
            q  = mb / ma;
            r  = (a[DataW-1] ^ b[DataW-1]) ? (32'd0 - q) : q;
          end
          ans = r;
          push_value(r);
        end
      end else begin
        push_value({24'd0, it.symbol} - {24'd0, SymZero});
      end
      if (it.end_of_expression) begin
        res.answer         = ans;
        res.divide_by_zero = dz;
        res.stack_overflow = ovf;
        answer_q.push_back(res);
        depth = 0;
        ans   = '0;
        dz    = 1'b0;
        ovf   = 1'b0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= ReportMax) begin
          $display("unexpected answer %0d dz %0b ovf %0b",
                   got.answer, got.divide_by_zero, got.stack_overflow);
        end
        return;
      end
      want = answer_q.pop_front();
      if (got.answer !== want.answer || got.divide_by_zero !== want.divide_by_zero ||
          got.stack_overflow !== want.stack_overflow) begin
        errors++;
        if (errors <= ReportMax) begin
          $display("answer mismatch: expected %0d dz %0b ovf %0b, got %0d dz %0b ovf %0b",
                   want.answer, want.divide_by_zero, want.stack_overflow,
                   got.answer, got.divide_by_zero, got.stack_overflow);
        end
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  rpn_scoreboard sb;
  int unsigned   items_sent   = 0;
  int unsigned   burst_left   = 0;
  int unsigned   rx_cycle     = 0;
  int unsigned   quiet_cycles = 0;

  rpn_stack_calculator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #10 clk = ~clk;

  // Receiver: cycle through always ready, coin flips, rare and slow windows.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: begin
        out_ready <= 1'b1;
      end
      2'd1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        out_ready <= (rx_cycle[2:0] == 3'd5);
      end
      default: begin
        out_ready <= rx_cycle[4];
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("** rpn_stack_calculator: FAILED **");
        $finish;
      end
    end
  end

  // Offer one item, often idling first when the current burst is used up.
  task automatic send_item(input logic [7:0] sym, input logic eoe);
    in_item_t    it;
    int unsigned gap;
    it.symbol            = sym;
    it.end_of_expression = eoe;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  function automatic logic [7:0] random_operand();
    logic [7:0] s;
    if ($urandom_range(0, 4) != 0) begin
      s = SymZero + 8'($urandom_range(0, 9));
    end else begin
      s = 8'($urandom_range(0, 255));
      if (s == SymAdd || s == SymSub || s == SymMul || s == SymDiv) begin
        s = SymZero;
      end
    end
    return s;
  endfunction

  function automatic logic [7:0] random_operator();
    logic [7:0] s;
    case ($urandom_range(0, 3))
      0: s = SymAdd;
      1: s = SymSub;
      2: s = SymMul;
      default: s = SymDiv;
    endcase
    return s;
  endfunction

  task automatic run_random();
    int unsigned first, kind, n, ops, operands_left, ops_left, level;
    logic [7:0] sym;
    first = items_sent;
    while (items_sent - first < RandomItems) begin
      kind = $urandom_range(0, 29);
      if (kind == 0) begin
        // fill the stack near or past its top, then fold up to four values
        n   = $urandom_range(StackDepth - 2, StackDepth + 6);
        ops = $urandom_range(0, 4);
        for (int i = 0; i < n + ops; i++) begin
          sym = (i < n) ? random_operand() : random_operator();
          send_item(sym, i == n + ops - 1);
        end
      end else if (kind < 4) begin
        // raw bytes, end mark optional so the next expression inherits the stack
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          send_item(8'($urandom_range(0, 255)), (i == n - 1) && ($urandom_range(0, 1) == 1));
        end
      end else begin
        operands_left = $urandom_range(1, 7);
        ops_left      = operands_left - 1 + (($urandom_range(0, 9) == 0) ? 1 : 0);
        level         = 0;
        while (operands_left + ops_left > 0) begin
          if (ops_left > 0 && (operands_left == 0 || (level >= 2 && $urandom_range(0, 1) == 1)))
          begin
            sym = random_operator();
            ops_left--;
            if (level > 0) begin
              level--;
            end
          end else begin
            sym = random_operand();
            operands_left--;
            level++;
          end
          send_item(sym, operands_left + ops_left == 0);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(SymAdd, EndExpr);               // pop from an empty stack
    send_item(8'd255, EndExpr);               // top byte, no arithmetic
    send_item(8'd0, MidExpr);
    send_item(SymZero + 8'd9, MidExpr);
    send_item(SymAdd, EndExpr);
    send_item(SymZero + 8'd7, MidExpr);
    send_item(SymZero, MidExpr);
    send_item(SymDiv, EndExpr);               // divide by zero
    send_item(SymZero + 8'd2, MidExpr);
    send_item(SymZero + 8'd7, MidExpr);
    send_item(SymSub, MidExpr);
    send_item(SymZero + 8'd3, MidExpr);
    send_item(SymDiv, EndExpr);               // negative quotient truncates
    // build the most negative value, then divide it by minus one
    send_item(8'd176, MidExpr);
    send_item(8'd176, MidExpr);
    send_item(SymMul, MidExpr);
    send_item(8'd176, MidExpr);
    send_item(SymMul, MidExpr);
    send_item(8'd176, MidExpr);
    send_item(SymMul, MidExpr);
    send_item(SymZero + 8'd8, MidExpr);
    send_item(SymMul, MidExpr);
    send_item(SymZero, MidExpr);
    send_item(SymZero + 8'd1, MidExpr);
    send_item(SymSub, MidExpr);
    send_item(SymDiv, EndExpr);

    run_random();

    in_valid <= 1'b0;
    while (sb.answer_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** rpn_stack_calculator: PASSED **");
    end else begin
      $display("** rpn_stack_calculator: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
